### hw/rtl/grey_box_blur_3x3_assert.svh
// ----------------------------------------------------------------------------
// grey_box_blur_3x3 assertion macros
// Short forms for the concurrent checks on the block's ports. Every macro
// samples on the rising edge of clk. The first two are disabled while rst_n
// is low. The third one also runs during reset.
// ----------------------------------------------------------------------------
`ifndef GREY_BOX_BLUR_3X3_ASSERT_SVH
`define GREY_BOX_BLUR_3X3_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define GBB_AST_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grey_box_blur_3x3 check failed");

// The consequent holds in the cycle after the antecedent.
`define GBB_AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grey_box_blur_3x3 check failed");

// Same as the previous macro, but with no reset gating, for checks on reset.
`define GBB_AST_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("grey_box_blur_3x3 reset check failed");

`endif

### hw/rtl/gbb_pkg.sv
// ----------------------------------------------------------------------------
// gbb_pkg
// Shared constants, register codes and stage structs for the grey 3x3
// box blur block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbb_pkg;

  // Widths of the pixel, configuration and counter fields.
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned CFG_W         = 12;
  localparam int unsigned COL_W         = 11;

  // Image size limits and reset values.
  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned HEIGHT_LIMIT  = 2048;
  localparam int unsigned MIN_SIZE      = 3;
  localparam int unsigned WIN_EDGE      = 2;
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  // Register port.
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned APB_AW        = 3;

  // Grey conversion: weights in units of 1/1024.
  localparam int unsigned W_FIRST       = 307;
  localparam int unsigned W_SECOND      = 604;
  localparam int unsigned W_THIRD       = 113;
  localparam int unsigned GREY_SHIFT    = 10;
  localparam int unsigned GREY_ACC_W    = 18;

  // Window mean: floor(sum / 9) is (sum * 3641) >> 15 for every sum of nine bytes.
  localparam int unsigned WIN_TAPS      = 9;
  localparam int unsigned SUM_W         = 12;
  localparam int unsigned DIV9_MUL      = 3641;
  localparam int unsigned DIV9_SHIFT    = 15;
  localparam int unsigned PROD_W        = 24;

  // Register index codes.
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } gbb_reg_t;

  // Image size in use after clamping.
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } gbb_size_t;

  // Per-pixel flags that travel with a request.
  typedef struct packed {
    logic emit;
    logic last;
    logic in_range;
  } gbb_meta_t;

  // Window sum handed from the window stage to the mean stage.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [SUM_W-1:0] sum;
  } gbb_sum_t;

endpackage

`default_nettype wire

### hw/rtl/gbb_if.sv
// ----------------------------------------------------------------------------
// gbb_if
// Valid/ready channel interfaces for the color pixel input and the
// blurred grey result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbb_in_if;
  logic                       valid;
  logic                       ready;
  logic [gbb_pkg::PIX_W-1:0]  chan_first;
  logic [gbb_pkg::PIX_W-1:0]  chan_second;
  logic [gbb_pkg::PIX_W-1:0]  chan_third;

  modport source (output valid, chan_first, chan_second, chan_third, input ready);
  modport sink   (input valid, chan_first, chan_second, chan_third, output ready);
endinterface

interface gbb_out_if;
  logic                       valid;
  logic                       ready;
  logic [gbb_pkg::PIX_W-1:0]  blur_value;
  logic                       frame_end;

  modport source (output valid, blur_value, frame_end, input ready);
  modport sink   (input valid, blur_value, frame_end, output ready);
endinterface

`default_nettype wire

### hw/rtl/gbb_cfg.sv
// ----------------------------------------------------------------------------
// gbb_cfg
// Register port holding image width and height. Also gives the sizes in use,
// clamped to the supported range.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_cfg #(
  parameter int unsigned MAX_WIDTH = gbb_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gbb_pkg::APB_AW-1:0]   paddr,
  input  wire logic [gbb_pkg::APB_DW-1:0]   pwdata,
  output logic      [gbb_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output gbb_pkg::gbb_size_t                size
);

  localparam int unsigned MW_BITS = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LW = (MW_BITS > gbb_pkg::CFG_W) ? MW_BITS : gbb_pkg::CFG_W;

  logic [gbb_pkg::CFG_W-1:0] width_r;
  logic [gbb_pkg::CFG_W-1:0] height_r;
  gbb_pkg::gbb_reg_t         reg_sel;
  logic                      wr_req;
  logic [LW-1:0]             width_x;
  logic [LW-1:0]             width_l;
  logic [gbb_pkg::CFG_W-1:0] height_l;

  assign pready  = 1'b1;
  assign reg_sel = gbb_pkg::gbb_reg_t'(paddr[gbb_pkg::APB_AW-1:2]);
  assign wr_req  = psel && penable && pwrite;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gbb_pkg::WIDTH_RST;
      height_r <= gbb_pkg::HEIGHT_RST;
    end else if (wr_req) begin
      case (reg_sel)
        gbb_pkg::REG_WIDTH:  width_r  <= pwdata[gbb_pkg::CFG_W-1:0];
        gbb_pkg::REG_HEIGHT: height_r <= pwdata[gbb_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data returns the stored register value.
  always_comb begin
    case (reg_sel)
      gbb_pkg::REG_WIDTH:  prdata = gbb_pkg::APB_DW'(width_r);
      gbb_pkg::REG_HEIGHT: prdata = gbb_pkg::APB_DW'(height_r);
      default:             prdata = '0;
    endcase
  end

  // Clamp the sizes to the range the line stores and counters support.
  always_comb begin
    width_x = LW'(width_r);
    if (width_x < LW'(gbb_pkg::MIN_SIZE)) begin
      width_l = LW'(gbb_pkg::MIN_SIZE);
    end else if (width_x > LW'(MAX_WIDTH)) begin
      width_l = LW'(MAX_WIDTH);
    end else begin
      width_l = width_x;
    end
    if (height_r < gbb_pkg::CFG_W'(gbb_pkg::MIN_SIZE)) begin
      height_l = gbb_pkg::CFG_W'(gbb_pkg::MIN_SIZE);
    end else if (height_r > gbb_pkg::CFG_W'(gbb_pkg::HEIGHT_LIMIT)) begin
      height_l = gbb_pkg::CFG_W'(gbb_pkg::HEIGHT_LIMIT);
    end else begin
      height_l = height_r;
    end
    size.width  = width_l[gbb_pkg::CFG_W-1:0];
    size.height = height_l;
  end

endmodule

`default_nettype wire

### hw/rtl/gbb_line_store.sv
// ----------------------------------------------------------------------------
// gbb_line_store
// One row of grey pixels. Simple dual-port memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_line_store #(
  parameter int unsigned DEPTH = gbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [gbb_pkg::PIX_W-1:0]   rd_data_r,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [gbb_pkg::PIX_W-1:0]   wr_data
);

  logic [gbb_pkg::PIX_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with a registered output.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gbb_window.sv
// ----------------------------------------------------------------------------
// gbb_window
// Grey conversion, line store write-back and the 3x3 window of grey values.
// Stage 1 holds the accepted pixel. Stage 2 holds the window and gives its sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_window #(
  parameter int unsigned AW = $clog2(gbb_pkg::MAX_WIDTH_DEF)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Accepted pixel from the input channel.
  input  wire logic                        acc,
  input  wire logic [gbb_pkg::PIX_W-1:0]   acc_first,
  input  wire logic [gbb_pkg::PIX_W-1:0]   acc_second,
  input  wire logic [gbb_pkg::PIX_W-1:0]   acc_third,
  input  wire gbb_pkg::gbb_meta_t          acc_meta,
  input  wire logic [AW-1:0]               acc_addr,
  output logic                             s1_ready,
  // Line store read data and write-back.
  input  wire logic [gbb_pkg::PIX_W-1:0]   up_data,
  input  wire logic [gbb_pkg::PIX_W-1:0]   lo_data,
  output logic                             wr_en,
  output logic      [AW-1:0]               wr_addr,
  output logic      [gbb_pkg::PIX_W-1:0]   wr_up_data,
  output logic      [gbb_pkg::PIX_W-1:0]   wr_lo_data,
  // Window sum toward the mean stage.
  output gbb_pkg::gbb_sum_t                sum_out,
  input  wire logic                        sum_ready
);

  logic                          s1_vld_r;
  logic [gbb_pkg::PIX_W-1:0]     s1_first_r;
  logic [gbb_pkg::PIX_W-1:0]     s1_second_r;
  logic [gbb_pkg::PIX_W-1:0]     s1_third_r;
  gbb_pkg::gbb_meta_t            s1_meta_r;
  logic [AW-1:0]                 s1_addr_r;
  logic                          s2_vld_r;
  gbb_pkg::gbb_meta_t            s2_meta_r;
  logic [gbb_pkg::PIX_W-1:0]     win_r [gbb_pkg::WIN_TAPS];

  logic                          s2_rdy;
  logic                          s1_adv;
  logic [gbb_pkg::GREY_ACC_W-1:0] grey_acc;
  logic [gbb_pkg::PIX_W-1:0]     grey;
  logic [gbb_pkg::PIX_W-1:0]     up_v;
  logic [gbb_pkg::PIX_W-1:0]     lo_v;
  logic [gbb_pkg::SUM_W-1:0]     win_sum;

  // Stage 2 frees up when its request leaves, or at once when it gives no result.
  assign s2_rdy   = !s2_vld_r || !s2_meta_r.emit || sum_ready;
  assign s1_adv   = s1_vld_r && s2_rdy;
  assign s1_ready = !s1_vld_r || s2_rdy;

  // Stage 1 pixel register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_first_r  <= acc_first;
      s1_second_r <= acc_second;
      s1_third_r  <= acc_third;
      s1_meta_r   <= acc_meta;
      s1_addr_r   <= acc_addr;
    end
  end

  // Weighted grey value, truncated to a byte.
  always_comb begin
    grey_acc = (gbb_pkg::GREY_ACC_W'(s1_first_r)  * gbb_pkg::GREY_ACC_W'(gbb_pkg::W_FIRST))
             + (gbb_pkg::GREY_ACC_W'(s1_second_r) * gbb_pkg::GREY_ACC_W'(gbb_pkg::W_SECOND))
             + (gbb_pkg::GREY_ACC_W'(s1_third_r)  * gbb_pkg::GREY_ACC_W'(gbb_pkg::W_THIRD));
    grey     = grey_acc[gbb_pkg::GREY_SHIFT +: gbb_pkg::PIX_W];
  end

  // A column beyond the line stores reads as zero and is not written.
  assign up_v = s1_meta_r.in_range ? up_data : '0;
  assign lo_v = s1_meta_r.in_range ? lo_data : '0;

  // Write-back: the lower row moves up and the new grey value enters below.
  assign wr_en      = s1_adv && s1_meta_r.in_range;
  assign wr_addr    = s1_addr_r;
  assign wr_up_data = lo_v;
  assign wr_lo_data = grey;

  // Window shift: each row moves one column left, and the new column enters on the right.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gbb_pkg::WIN_TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]     <= win_r[k*3 + 1];
        win_r[k*3 + 1] <= win_r[k*3 + 2];
      end
      win_r[2] <= up_v;
      win_r[5] <= lo_v;
      win_r[8] <= grey;
    end
  end

  // Stage 2 control travels alongside the window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  // Sum of the nine window values.
  always_comb begin
    win_sum = '0;
    for (int i = 0; i < gbb_pkg::WIN_TAPS; i++) begin
      win_sum = win_sum + gbb_pkg::SUM_W'(win_r[i]);
    end
  end

  assign sum_out.valid = s2_vld_r && s2_meta_r.emit;
  assign sum_out.last  = s2_meta_r.last;
  assign sum_out.sum   = win_sum;

endmodule

`default_nettype wire

### hw/rtl/gbb_mean.sv
// ----------------------------------------------------------------------------
// gbb_mean
// Divides the window sum by nine with a reciprocal multiply, then holds the
// result in the output register that drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_mean (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gbb_pkg::gbb_sum_t  sum_in,
  output logic                    sum_ready,
  gbb_out_if.source               out_chan
);

  logic                        s3_vld_r;
  logic                        s3_last_r;
  logic [gbb_pkg::SUM_W-1:0]   s3_sum_r;
  logic                        out_vld_r;
  logic                        out_last_r;
  logic [gbb_pkg::PIX_W-1:0]   blur_r;

  logic                        o_rdy;
  logic [gbb_pkg::PROD_W-1:0]  prod;
  logic [gbb_pkg::PIX_W-1:0]   quot;

  assign o_rdy     = !out_vld_r || out_chan.ready;
  assign sum_ready = !s3_vld_r || o_rdy;

  // Stage 3 sum register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (sum_ready) begin
      s3_vld_r <= sum_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_in.valid) begin
      s3_sum_r  <= sum_in.sum;
      s3_last_r <= sum_in.last;
    end
  end

  // Truncated quotient by nine.
  always_comb begin
    prod = gbb_pkg::PROD_W'(s3_sum_r) * gbb_pkg::PROD_W'(gbb_pkg::DIV9_MUL);
    quot = prod[gbb_pkg::DIV9_SHIFT +: gbb_pkg::PIX_W];
  end

  // Output register: holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (o_rdy) begin
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && s3_vld_r) begin
      blur_r     <= quot;
      out_last_r <= s3_last_r;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.blur_value = blur_r;
  assign out_chan.frame_end  = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/grey_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// grey_box_blur_3x3
// Color to grey conversion followed by a 3x3 box mean over interior pixels.
// ----------------------------------------------------------------------------
// Color pixels arrive on in_chan in raster order, one per request, with the
// three channel bytes. Each interior pixel gives one request on out_chan with
// the truncated 3x3 mean of its grey neighborhood. frame_end marks the last
// interior pixel of a frame. Border pixels give no result.
// Image width and height are set through the register port (width at byte
// address 0, height at 4) and are clamped to 3..MAX_WIDTH and 3..2048.
// Throughput is one pixel per clock. Each stage has its own valid bit, so
// the pipeline keeps taking pixels while a result waits in the output
// register, until the stages behind that result are full.
// From input acceptance to out_chan.valid a pixel passes through the line
// store read and pixel register, the window, the nine-value sum, and the
// reciprocal multiply with the output register.
// Reset empties the pipeline, clears the window and the row and column
// counters, and restores 640x480. The line stores are not cleared: an entry
// read before it is written only reaches window values that are shifted out
// before any result uses them.
// ----------------------------------------------------------------------------
`default_nettype none

module grey_box_blur_3x3 #(
  parameter int unsigned MAX_WIDTH = gbb_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  gbb_in_if.sink                           in_chan,
  gbb_out_if.source                        out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gbb_pkg::APB_AW-1:0]  paddr,
  input  wire logic [gbb_pkg::APB_DW-1:0]  pwdata,
  output logic      [gbb_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned XW = (AW + 1 > gbb_pkg::COL_W) ? AW + 1 : gbb_pkg::COL_W;

  gbb_pkg::gbb_size_t              size;
  gbb_pkg::gbb_meta_t              acc_meta;
  gbb_pkg::gbb_sum_t               win_sum;
  logic                            sum_ready;
  logic                            s1_ready;
  logic                            in_fire;

  logic [gbb_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [gbb_pkg::COL_W-1:0]       row_r, row_nxt;
  logic [gbb_pkg::CFG_W-1:0]       col_x;
  logic [gbb_pkg::CFG_W-1:0]       row_x;
  logic                            col_wrap;
  logic                            row_wrap;
  logic [XW-1:0]                   col_ax;
  logic [AW-1:0]                   acc_addr;

  logic [gbb_pkg::PIX_W-1:0]       up_data;
  logic [gbb_pkg::PIX_W-1:0]       lo_data;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [gbb_pkg::PIX_W-1:0]       wr_up_data;
  logic [gbb_pkg::PIX_W-1:0]       wr_lo_data;

  gbb_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size    (size)
  );

  assign in_chan.ready = s1_ready;
  assign in_fire       = in_chan.valid && s1_ready;

  // Position of the incoming pixel and the flags it carries.
  always_comb begin
    col_x    = gbb_pkg::CFG_W'(col_r);
    row_x    = gbb_pkg::CFG_W'(row_r);
    col_wrap = (col_x + gbb_pkg::CFG_W'(1)) >= size.width;
    row_wrap = (row_x + gbb_pkg::CFG_W'(1)) >= size.height;

    acc_meta.emit = (row_x >= gbb_pkg::CFG_W'(gbb_pkg::WIN_EDGE)) && (row_x < size.height)
                 && (col_x >= gbb_pkg::CFG_W'(gbb_pkg::WIN_EDGE)) && (col_x < size.width);
    acc_meta.last = (row_x == size.height - gbb_pkg::CFG_W'(1))
                 && (col_x == size.width - gbb_pkg::CFG_W'(1));

    col_ax            = XW'(col_r);
    acc_meta.in_range = col_ax < XW'(MAX_WIDTH);
    acc_addr          = col_ax[AW-1:0];

    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_wrap ? '0 : row_r + gbb_pkg::COL_W'(1);
    end else begin
      col_nxt = col_r + gbb_pkg::COL_W'(1);
      row_nxt = row_r;
    end
  end

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line stores for the two rows above, read as the pixel is accepted.
  gbb_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_store_upper (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr   (acc_addr),
    .rd_data_r (up_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_up_data)
  );

  gbb_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_store_lower (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr   (acc_addr),
    .rd_data_r (lo_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_lo_data)
  );

  gbb_window #(
    .AW (AW)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_fire),
    .acc_first  (in_chan.chan_first),
    .acc_second (in_chan.chan_second),
    .acc_third  (in_chan.chan_third),
    .acc_meta   (acc_meta),
    .acc_addr   (acc_addr),
    .s1_ready   (s1_ready),
    .up_data    (up_data),
    .lo_data    (lo_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_up_data (wr_up_data),
    .wr_lo_data (wr_lo_data),
    .sum_out    (win_sum),
    .sum_ready  (sum_ready)
  );

  gbb_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_in    (win_sum),
    .sum_ready (sum_ready),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

### hw/rtl/gbb_checker.sv
// ----------------------------------------------------------------------------
// gbb_checker
// Port-level checks on the grey 3x3 box blur block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grey_box_blur_3x3_assert.svh"

module gbb_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_ready,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [gbb_pkg::PIX_W-1:0]  blur_value,
  input  wire logic                       frame_end
);

  // Reset leaves no result pending.
  `GBB_AST_RST(a_reset_empties_out, !rst_n, !out_valid)

  // With the output register empty, every stage can move, so input is taken.
  `GBB_AST_NOW(a_idle_out_takes_input, !out_valid, in_ready)

  // A stalled result stays offered.
  `GBB_AST_NXT(a_out_valid_holds, out_valid && !out_ready, out_valid)

  // A stalled result keeps its value.
  `GBB_AST_NXT(a_out_payload_holds, out_valid && !out_ready, $stable(blur_value) && $stable(frame_end))

endmodule

bind grey_box_blur_3x3 gbb_checker u_gbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .blur_value (out_chan.blur_value),
  .frame_end  (out_chan.frame_end)
);

`default_nettype wire

### tb/tb_grey_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// tb_grey_box_blur_3x3
// Self-checking bench for the grey 3x3 box blur block.
// ----------------------------------------------------------------------------
// Color pixels are sent as whole frames after the image size is set through
// the register port, including sizes below the lower clamp limit. A
// predictor converts every accepted pixel to grey, keeps its own line stores
// and window, and queues the expected mean for each interior pixel. Results
// are compared in order, field by field. Both channels idle at random in the
// first two of three passes; in the third neither channel idles.
// ----------------------------------------------------------------------------

module tb_grey_box_blur_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W          = 2048;
  localparam int unsigned HEIGHT_MAX     = 2048;
  localparam int unsigned WEIGHT_FIRST   = 307;
  localparam int unsigned WEIGHT_SECOND  = 604;
  localparam int unsigned WEIGHT_THIRD   = 113;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned ITEMS_PER_PASS = 400;

  typedef struct packed {
    logic [gbb_pkg::PIX_W-1:0] c0;
    logic [gbb_pkg::PIX_W-1:0] c1;
    logic [gbb_pkg::PIX_W-1:0] c2;
  } pixel_t;

  typedef struct packed {
    logic [gbb_pkg::PIX_W-1:0] blur;
    logic                      frame_end;
  } blur_t;

  typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_PRIMARIES} fill_t;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [gbb_pkg::APB_AW-1:0]   paddr;
  logic [gbb_pkg::APB_DW-1:0]   pwdata;
  logic [gbb_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  gbb_in_if  pix_if ();
  gbb_out_if blur_if ();

  grey_box_blur_3x3 DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_if),
    .out_chan (blur_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: size registers, line stores, window and raster counters.
  logic [gbb_pkg::CFG_W-1:0] width_reg;
  logic [gbb_pkg::CFG_W-1:0] height_reg;
  logic [gbb_pkg::PIX_W-1:0] upper_row [MAX_W];
  logic [gbb_pkg::PIX_W-1:0] lower_row [MAX_W];
  logic [gbb_pkg::PIX_W-1:0] window [9];
  logic [gbb_pkg::COL_W-1:0] col_cnt;
  logic [gbb_pkg::COL_W-1:0] row_cnt;

  // Stimulus and scoreboard bookkeeping.
  pixel_t      pixel_q [$];
  blur_t       blur_due_q [$];
  pixel_t      drive_px;
  pixel_t      taken_px;
  blur_t       due;
  logic        pix_taken;
  int unsigned pushed_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned fault_count    = 0;
  int unsigned stall_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;

  function automatic int unsigned size_in_use(input logic [gbb_pkg::CFG_W-1:0] v,
                                              input int unsigned hi);
    if (v < gbb_pkg::MIN_SIZE) return gbb_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the predictor by one pixel; returns 1 when an interior result is due.
  function automatic bit predict_blur(input pixel_t px, output blur_t res);
    int unsigned w_use;
    int unsigned h_use;
    int unsigned col;
    int unsigned row;
    int unsigned box_sum;
    int          k;
    logic [gbb_pkg::PIX_W-1:0] grey;
    logic [gbb_pkg::PIX_W-1:0] up;
    logic [gbb_pkg::PIX_W-1:0] lo;
    bit emit;
    w_use = size_in_use(width_reg, MAX_W);
    h_use = size_in_use(height_reg, HEIGHT_MAX);
    col = col_cnt;
    row = row_cnt;
    grey = gbb_pkg::PIX_W'((WEIGHT_FIRST * px.c0 + WEIGHT_SECOND * px.c1
                            + WEIGHT_THIRD * px.c2) >> 10);

    // Line stores advance one row at this column: the lower row moves up.
    up = upper_row[col];
    lo = lower_row[col];
    upper_row[col] = lo;
    lower_row[col] = grey;

    // The window moves one column to the left, new column on the right.
    for (k = 0; k < 3; k++) begin
      window[k * 3]     = window[k * 3 + 1];
      window[k * 3 + 1] = window[k * 3 + 2];
    end
    window[2] = up;
    window[5] = lo;
    window[8] = grey;

    res = '0;
    emit = (row >= 2) && (row < h_use) && (col >= 2) && (col < w_use);
    if (emit) begin
      box_sum = 0;
      for (k = 0; k < 9; k++) box_sum += window[k];
      res.blur = gbb_pkg::PIX_W'(box_sum / 9);
      res.frame_end = (row == h_use - 1) && (col == w_use - 1);
    end

    // Raster counters wrap at the size in use.
    if (col + 1 >= w_use) begin
      col_cnt = '0;
      row_cnt = (row + 1 >= h_use) ? '0 : gbb_pkg::COL_W'(row + 1);
    end else begin
      col_cnt = gbb_pkg::COL_W'(col + 1);
    end
    return emit;
  endfunction

  function automatic logic [gbb_pkg::PIX_W-1:0] pick_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return gbb_pkg::PIX_W'($urandom);
    endcase
  endfunction

  task automatic note_fault(input string msg);
    if (fault_count < 10) $display("mismatch: %s", msg);
    fault_count++;
  endtask

  // Wait until every pixel is taken and every result has come, then let the
  // pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != pushed_count || blur_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle. Upper data bits are noise.
  task automatic write_reg(input gbb_pkg::gbb_reg_t idx,
                           input logic [gbb_pkg::CFG_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(gbb_pkg::APB_DW - gbb_pkg::CFG_W)'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == gbb_pkg::REG_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  // Set the image size while idle, then queue whole frames of pixels.
  task automatic run_frames(input logic [gbb_pkg::CFG_W-1:0] wv,
                            input logic [gbb_pkg::CFG_W-1:0] hv,
                            input int unsigned nframes, input bit pause_mid,
                            input fill_t fill);
    int unsigned total;
    int unsigned k;
    pixel_t      px;
    wait_drained();
    write_reg(gbb_pkg::REG_WIDTH, wv);
    write_reg(gbb_pkg::REG_HEIGHT, hv);
    total = nframes * size_in_use(wv, MAX_W) * size_in_use(hv, HEIGHT_MAX);
    for (k = 0; k < total; k++) begin
      if (pause_mid && k == total / 2) wait_drained();
      case (fill)
        FILL_WHITE: px = '1;
        FILL_PRIMARIES: begin
          case (k % 5)
            0: px = '0;
            1: px = {8'hFF, 8'h00, 8'h00};
            2: px = {8'h00, 8'hFF, 8'h00};
            3: px = {8'h00, 8'h00, 8'hFF};
            default: px = '1;
          endcase
        end
        default: px = {pick_channel(), pick_channel(), pick_channel()};
      endcase
      pixel_q.push_back(px);
      pushed_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pixel driver: presents the next queued pixel once the previous one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_px = pixel_q.pop_front();
        pix_if.valid       <= 1'b1;
        pix_if.chan_first  <= drive_px.c0;
        pix_if.chan_second <= drive_px.c1;
        pix_if.chan_third  <= drive_px.c2;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver backpressure.
  always @(negedge clk) begin
    blur_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Predict on every accepted pixel and check every accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_taken <= 1'b0;
    end else begin
      pix_taken <= pix_if.valid && pix_if.ready;
      if (pix_if.valid && pix_if.ready) begin
        taken_px = {pix_if.chan_first, pix_if.chan_second, pix_if.chan_third};
        accepted_count++;
        if (predict_blur(taken_px, due)) blur_due_q.push_back(due);
      end
      if (blur_if.valid && blur_if.ready) begin
        if (blur_due_q.size() == 0) begin
          note_fault($sformatf("result with none expected: blur_value %0d frame_end %0b",
                               blur_if.blur_value, blur_if.frame_end));
        end else begin
          due = blur_due_q.pop_front();
          if (blur_if.blur_value !== due.blur)
            note_fault($sformatf("blur_value expected %0d got %0d",
                                 due.blur, blur_if.blur_value));
          if (blur_if.frame_end !== due.frame_end)
            note_fault($sformatf("frame_end expected %0b got %0b (blur_value %0d)",
                                 due.frame_end, blur_if.frame_end, due.blur));
        end
      end
      if ((pix_if.valid && pix_if.ready) || (blur_if.valid && blur_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog: too long without any request on either channel.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned pass_idx;
    int unsigned pass_start;
    int          k;
    logic [gbb_pkg::CFG_W-1:0] wv;
    logic [gbb_pkg::CFG_W-1:0] hv;

    // Known values on every input from time zero.
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pix_if.valid       = 1'b0;
    pix_if.chan_first  = '0;
    pix_if.chan_second = '0;
    pix_if.chan_third  = '0;
    blur_if.ready      = 1'b0;

    // Predictor after reset.
    width_reg  = gbb_pkg::WIDTH_RST;
    height_reg = gbb_pkg::HEIGHT_RST;
    for (k = 0; k < MAX_W; k++) begin
      upper_row[k] = '0;
      lower_row[k] = '0;
    end
    for (k = 0; k < 9; k++) window[k] = '0;
    col_cnt = '0;
    row_cnt = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 66;

    // Directed: sizes below the minimum clamp to 3, all-white and primaries.
    run_frames(12'd1, 12'd2, 1, 1'b0, FILL_WHITE);
    run_frames(12'd4, 12'd0, 1, 1'b1, FILL_PRIMARIES);

    // Random frames in three idle passes.
    for (pass_idx = 0; pass_idx < 3; pass_idx++) begin
      case (pass_idx)
        0: begin send_idle_pct = 28; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      pass_start = pushed_count;
      while (pushed_count - pass_start < ITEMS_PER_PASS) begin
        wv = ($urandom_range(7) == 0) ? gbb_pkg::CFG_W'($urandom_range(2)) :
                                        gbb_pkg::CFG_W'($urandom_range(12, 3));
        hv = ($urandom_range(7) == 0) ? gbb_pkg::CFG_W'($urandom_range(2)) :
                                        gbb_pkg::CFG_W'($urandom_range(8, 3));
        run_frames(wv, hv, $urandom_range(3, 1), ($urandom_range(4) == 0), FILL_RANDOM);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fault_count == 0 && blur_due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
